// ----- sv/assert_macros.svh -----
// Assertion helpers, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property
`define LBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication
`define LBS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);

`endif

// ----- sv/lbs_pkg.sv -----
package lbs_pkg;

  localparam int MAT_ELEMS        = 12;
  localparam int FIELD_INFLUENCES = 4;
  localparam int W_BITS           = 16;
  localparam int J_BITS           = 8;
  localparam int QW               = 32;
  localparam int DIV_STAGES       = QW;
  localparam int LANE_LAT         = 4;
  localparam int RECIP_12         = 2731;
  localparam int RECIP_SHIFT      = 15;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SKIN = 1'b1;

  localparam logic REG_MIN_WEIGHT   = 1'b0;
  localparam logic REG_PALETTE_SIZE = 1'b1;

  localparam logic [1:0] PATH_BLEND  = 2'd0;
  localparam logic [1:0] PATH_JOINT0 = 2'd1;
  localparam logic [1:0] PATH_EMPTY  = 2'd2;

  typedef struct packed {
    logic signed [31:0] t_x;
    logic signed [31:0] t_y;
    logic signed [31:0] t_z;
    logic signed [47:0] p_x;
    logic signed [47:0] p_y;
    logic signed [47:0] p_z;
  } lane_out_t;

endpackage

// ----- sv/lbs_lane.sv -----
module lbs_lane import lbs_pkg::*; #(
  parameter int MAX_JOINTS = 128
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [J_BITS-1:0]   wr_joint,
  input  logic [3:0]          wr_elem,
  input  logic [31:0]         wr_data,
  input  logic [J_BITS-1:0]   rd_joint,
  input  logic [W_BITS-1:0]   weight,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  output lane_out_t           res
);

  localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [31:0]        mem [MAT_ELEMS][MAX_JOINTS];
  logic signed [31:0] rd  [MAT_ELEMS];
  logic signed [31:0] pos [3];
  logic [W_BITS-1:0]  w1, w2, w3;
  logic signed [47:0] fl  [9];
  logic signed [31:0] tr  [3];
  logic signed [31:0] t   [3];

  for (genvar e = 0; e < MAT_ELEMS; e++) begin : g_bank
    always_ff @(posedge clk) begin
      if (wr_en && wr_elem == 4'(e)) mem[e][wr_joint[JW-1:0]] <= wr_data;
      rd[e] <= mem[e][rd_joint[JW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    pos[0] <= pos_x;
    pos[1] <= pos_y;
    pos[2] <= pos_z;
    w1 <= weight;
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] prod;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod = rd[r*4+c] * pos[c];
        fl[r*3+c] <= prod[63:16];
      end
      tr[r] <= rd[r*4+3];
    end
    w2 <= w1;
  end

  always_ff @(posedge clk) begin
    logic signed [49:0] sum;
    for (int r = 0; r < 3; r++) begin
      sum = 50'(fl[r*3]) + 50'(fl[r*3+1]) + 50'(fl[r*3+2]) + 50'(tr[r]);
      t[r] <= sat32(sum);
    end
    w3 <= w2;
  end

  always_ff @(posedge clk) begin
    logic signed [16:0] ws;
    ws = $signed({1'b0, w3});
    res.t_x <= t[0];
    res.t_y <= t[1];
    res.t_z <= t[2];
    res.p_x <= (w3 != '0) ? 48'(t[0]) * 48'(ws) : '0;
    res.p_y <= (w3 != '0) ? 48'(t[1]) * 48'(ws) : '0;
    res.p_z <= (w3 != '0) ? 48'(t[2]) * 48'(ws) : '0;
  end

endmodule

// ----- sv/lbs_div.sv -----
module lbs_div import lbs_pkg::*; #(
  parameter int TW = 18
) (
  input  logic               clk,
  input  logic [TW+QW:0]     num,
  input  logic [TW-1:0]      den,
  input  logic               neg,
  output logic signed [31:0] quot
);

  localparam int NW = TW + QW + 1;

  logic [TW-1:0] r  [DIV_STAGES+1];
  logic [QW-1:0] lo [DIV_STAGES+1];
  logic [QW-1:0] q  [DIV_STAGES+1];
  logic [TW-1:0] d  [DIV_STAGES+1];
  logic          ng [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    r[0]  <= TW'(num[NW-1:QW]);
    lo[0] <= num[QW-1:0];
    q[0]  <= '0;
    d[0]  <= den;
    ng[0] <= neg;
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [TW:0] rs;
    logic        ge;
    assign rs = {r[s], lo[s][QW-1]};
    assign ge = rs >= {1'b0, d[s]};
    always_ff @(posedge clk) begin
      r[s+1]  <= ge ? TW'(rs - {1'b0, d[s]}) : TW'(rs);
      lo[s+1] <= {lo[s][QW-2:0], 1'b0};
      q[s+1]  <= {q[s][QW-2:0], ge};
      d[s+1]  <= d[s];
      ng[s+1] <= ng[s];
    end
  end

  always_comb begin
    if (ng[DIV_STAGES])      quot = $signed(~q[DIV_STAGES] + 32'd1);
    else if (q[DIV_STAGES][QW-1]) quot = 32'sh7fffffff;
    else                     quot = $signed(q[DIV_STAGES]);
  end

endmodule

// ----- sv/linear_blend_vertex_skinning_core.sv -----
// Channel   Handshake          Fields
// command   start / busy       cmd palette_addr palette_value pos_x pos_y pos_z
//                              joint_ids weight_word
// result    done (strobe)      world_x world_y world_z path_taken
// config    cfg_write          cfg_index cfg_data
//
// One command word is taken every cycle; busy stays low.
// A skin word's result passes the lane pipelines (palette read, products, sum,
// weighting), a merge register, the bit-per-stage divider and an output register.
// Load words give no result. Reset clears the pipeline valids and done and sets
// min_weight to 66 and palette_size to 0; the palette holds garbage until loaded.
// The receiver cannot stall, so nothing back-pressures.
module linear_blend_vertex_skinning_core import lbs_pkg::*; #(
  parameter int MAX_JOINTS = 128,
  parameter int INFLUENCES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [10:0]        palette_addr,
  input  logic signed [31:0] palette_value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [31:0]        joint_ids,
  input  logic [63:0]        weight_word,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] world_x,
  output logic signed [31:0] world_y,
  output logic signed [31:0] world_z,
  output logic [1:0]         path_taken
);

  `include "assert_macros.svh"

  localparam int LN        = (INFLUENCES < FIELD_INFLUENCES) ? INFLUENCES : FIELD_INFLUENCES;
  localparam int TW        = W_BITS + $clog2(LN);
  localparam int AW        = 48 + $clog2(LN);
  localparam int NW        = TW + QW + 1;
  localparam int SD        = DIV_STAGES + 2;
  localparam int TOTAL_LAT = LANE_LAT + 1 + 1 + DIV_STAGES + 1;

  typedef struct packed {
    logic [1:0]         path;
    logic signed [31:0] fb_x;
    logic signed [31:0] fb_y;
    logic signed [31:0] fb_z;
  } side_t;

  logic [15:0] min_weight;
  logic [7:0]  palette_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_weight   <= 16'd66;
      palette_size <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_WEIGHT:   min_weight   <= cfg_data;
        REG_PALETTE_SIZE: palette_size <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic        accept_skin;
  logic [22:0] dq;
  logic [J_BITS-1:0] wr_joint;
  logic [3:0]  wr_elem;
  logic        wr_en;
  logic [8:0]  eff_size;

  assign accept_skin = start && !busy && cmd == CMD_SKIN;
  assign dq       = {12'd0, palette_addr} * 23'(RECIP_12);
  assign wr_joint = dq[RECIP_SHIFT+J_BITS-1:RECIP_SHIFT];
  assign wr_elem  = 4'(palette_addr - 11'(wr_joint) * 11'(MAT_ELEMS));
  assign wr_en    = start && !busy && cmd == CMD_LOAD &&
                    13'(palette_addr) < 13'(MAX_JOINTS * MAT_ELEMS);
  assign eff_size = ({1'b0, palette_size} > 9'(MAX_JOINTS)) ? 9'(MAX_JOINTS)
                                                            : {1'b0, palette_size};

  lane_out_t         lane_res [LN];
  lane_out_t         fb_res;
  logic [W_BITS-1:0] wg [LN];

  for (genvar k = 0; k < LN; k++) begin : g_lane
    logic [W_BITS-1:0] w;
    logic [J_BITS-1:0] j;
    logic              ok;
    assign w  = weight_word[W_BITS*k +: W_BITS];
    assign j  = joint_ids[J_BITS*k +: J_BITS];
    assign ok = w > min_weight && {1'b0, j} < eff_size;
    assign wg[k] = ok ? w : '0;

    lbs_lane #(.MAX_JOINTS(MAX_JOINTS)) u_lane (
      .clk      (clk),
      .wr_en    (wr_en),
      .wr_joint (wr_joint),
      .wr_elem  (wr_elem),
      .wr_data  (palette_value),
      .rd_joint (ok ? j : '0),
      .weight   (wg[k]),
      .pos_x    (pos_x),
      .pos_y    (pos_y),
      .pos_z    (pos_z),
      .res      (lane_res[k])
    );
  end

  lbs_lane #(.MAX_JOINTS(MAX_JOINTS)) u_fallback (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_joint (wr_joint),
    .wr_elem  (wr_elem),
    .wr_data  (palette_value),
    .rd_joint ('0),
    .weight   ('0),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .res      (fb_res)
  );

  logic ev  [LANE_LAT];
  logic esz [LANE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) ev[i] <= 1'b0;
    end else begin
      ev[0] <= accept_skin;
      for (int i = 1; i < LANE_LAT; i++) ev[i] <= ev[i-1];
    end
  end

  always_ff @(posedge clk) begin
    esz[0] <= eff_size == '0;
    for (int i = 1; i < LANE_LAT; i++) esz[i] <= esz[i-1];
  end

  logic signed [AW-1:0] acc_x, acc_y, acc_z;
  logic [TW-1:0]        total;

  always_comb begin
    acc_x = '0;
    acc_y = '0;
    acc_z = '0;
    for (int k = 0; k < LN; k++) begin
      acc_x = acc_x + AW'(lane_res[k].p_x);
      acc_y = acc_y + AW'(lane_res[k].p_y);
      acc_z = acc_z + AW'(lane_res[k].p_z);
    end
  end

  // Weights as seen by the lanes, delayed to line up with the products
  logic [W_BITS-1:0] wd [LANE_LAT][LN];

  always_ff @(posedge clk) begin
    for (int k = 0; k < LN; k++) begin
      wd[0][k] <= wg[k];
      for (int i = 1; i < LANE_LAT; i++) wd[i][k] <= wd[i-1][k];
    end
  end

  logic [TW-1:0] tsum;

  always_comb begin
    tsum = '0;
    for (int k = 0; k < LN; k++) tsum = tsum + TW'(wd[LANE_LAT-1][k]);
  end

  assign total = tsum;

  function automatic logic [NW-1:0] blend_num(input logic signed [AW-1:0] a,
                                              input logic [TW-1:0] d);
    logic [AW-1:0] mag;
    mag = a[AW-1] ? AW'(-a) : AW'(a);
    return NW'(mag) + NW'(d >> 1);
  endfunction

  logic [NW-1:0]     mg_num_x, mg_num_y, mg_num_z;
  logic              mg_neg_x, mg_neg_y, mg_neg_z;
  logic [TW-1:0]     mg_den;
  side_t             side_d [SD];
  logic              vd     [SD];

  always_ff @(posedge clk) begin
    mg_num_x <= blend_num(acc_x, total);
    mg_num_y <= blend_num(acc_y, total);
    mg_num_z <= blend_num(acc_z, total);
    mg_neg_x <= acc_x[AW-1];
    mg_neg_y <= acc_y[AW-1];
    mg_neg_z <= acc_z[AW-1];
    mg_den   <= (total == '0) ? TW'(1) : total;
    if (total > TW'(min_weight)) side_d[0].path <= PATH_BLEND;
    else if (esz[LANE_LAT-1])    side_d[0].path <= PATH_EMPTY;
    else                         side_d[0].path <= PATH_JOINT0;
    side_d[0].fb_x <= fb_res.t_x;
    side_d[0].fb_y <= fb_res.t_y;
    side_d[0].fb_z <= fb_res.t_z;
    for (int i = 1; i < SD; i++) side_d[i] <= side_d[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SD; i++) vd[i] <= 1'b0;
    end else begin
      vd[0] <= ev[LANE_LAT-1];
      for (int i = 1; i < SD; i++) vd[i] <= vd[i-1];
    end
  end

  logic signed [31:0] qx, qy, qz;

  lbs_div #(.TW(TW)) u_div_x (.clk(clk), .num(mg_num_x), .den(mg_den), .neg(mg_neg_x),
                              .quot(qx));
  lbs_div #(.TW(TW)) u_div_y (.clk(clk), .num(mg_num_y), .den(mg_den), .neg(mg_neg_y),
                              .quot(qy));
  lbs_div #(.TW(TW)) u_div_z (.clk(clk), .num(mg_num_z), .den(mg_den), .neg(mg_neg_z),
                              .quot(qz));

  side_t so;
  assign so = side_d[SD-1];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vd[SD-1];
  end

  always_ff @(posedge clk) begin
    path_taken <= so.path;
    case (so.path)
      PATH_BLEND: begin
        world_x <= qx;
        world_y <= qy;
        world_z <= qz;
      end
      PATH_JOINT0: begin
        world_x <= so.fb_x;
        world_y <= so.fb_y;
        world_z <= so.fb_z;
      end
      default: begin
        world_x <= '0;
        world_y <= '0;
        world_z <= '0;
      end
    endcase
  end

  `LBS_ASSERT_IMPL(a_skin_gives_result, accept_skin, ##TOTAL_LAT done, "skin word lost")
  `LBS_ASSERT_IMPL(a_result_has_source, done, $past(accept_skin, TOTAL_LAT), "orphan result")
  `LBS_ASSERT_IMPL(a_empty_is_zero, done && path_taken == PATH_EMPTY, world_x == 0 && world_y == 0 && world_z == 0, "empty palette result not zero")

endmodule
